// ===== rtl/ascon_pkg.sv =====
// Shared types, constants and round functions for the Ascon AEAD engine.
package ascon_pkg;

  localparam int TDATA_W = 136;

  typedef logic [4:0][63:0] state_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_AD    = 2'd1,
    KIND_MSG   = 2'd2,
    KIND_FIN   = 2'd3
  } item_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_AD   = 2'd1,
    PH_MSG  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    CFG_VARIANT   = 3'd0,
    CFG_DECRYPT   = 3'd1,
    CFG_KEY_EXTRA = 3'd2,
    CFG_KEY_HI    = 3'd3,
    CFG_KEY_LO    = 3'd4
  } cfg_index_t;

  localparam logic [1:0] VAR_80PQ = 2'd0;
  localparam logic [1:0] VAR_128  = 2'd1;
  localparam logic [1:0] VAR_128A = 2'd2;

  localparam logic OUT_KIND_DATA = 1'b0;
  localparam logic OUT_KIND_TAG  = 1'b1;

  localparam logic [31:0] IV_80PQ = 32'hA040_0C06;
  localparam logic [31:0] IV_128  = 32'h8040_0C06;
  localparam logic [31:0] IV_128A = 32'h8080_0C08;

  localparam logic [3:0] ROUND_FULL_START = 4'd0;
  localparam logic [3:0] ROUND_128A_START = 4'd4;
  localparam logic [3:0] ROUND_128_START  = 4'd6;
  localparam logic [3:0] ROUND_LAST       = 4'd11;

  localparam logic [4:0] RATE_NARROW = 5'd8;
  localparam logic [4:0] RATE_WIDE   = 5'd16;
  localparam logic [4:0] TAG_BYTES   = 5'd16;
  localparam logic [3:0] LANE_BYTES  = 4'd8;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_ROUND,
    DP_INIT_KEY,
    DP_AD_ABS,
    DP_PAD0,
    DP_SEP,
    DP_MSG,
    DP_FIN_KEY,
    DP_TAG
  } dp_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ROUND,
    ST_INIT_KEY,
    ST_SEP,
    ST_MSG,
    ST_FIN_KEY,
    ST_TAG
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] round_idx;
    logic       pad_en;
    logic       load_item;
  } dp_cmd_t;

  typedef struct packed {
    item_kind_t kind;
    logic       full;
    logic       nonzero;
    logic       wide;
  } dp_status_t;

  function automatic logic [63:0] rotr(logic [63:0] v, int n);
    return (v >> n) | (v << (64 - n));
  endfunction

  function automatic state_t ascon_round(state_t s, logic [3:0] r);
    logic [63:0] x0, x1, x2, x3, x4;
    logic [63:0] t0, t1, t2, t3, t4;
    logic [7:0]  rc;
    rc = {4'hf - r, r};
    x0 = s[0];
    x1 = s[1];
    x2 = s[2] ^ {56'd0, rc};
    x3 = s[3];
    x4 = s[4];
    x0 = x0 ^ x4;
    x4 = x4 ^ x3;
    x2 = x2 ^ x1;
    t0 = ~x0 & x1;
    t1 = ~x1 & x2;
    t2 = ~x2 & x3;
    t3 = ~x3 & x4;
    t4 = ~x4 & x0;
    x0 = x0 ^ t1;
    x1 = x1 ^ t2;
    x2 = x2 ^ t3;
    x3 = x3 ^ t4;
    x4 = x4 ^ t0;
    x1 = x1 ^ x0;
    x0 = x0 ^ x4;
    x3 = x3 ^ x2;
    x2 = ~x2;
    x0 = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
    x1 = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
    x2 = x2 ^ rotr(x2, 1)  ^ rotr(x2, 6);
    x3 = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
    x4 = x4 ^ rotr(x4, 7)  ^ rotr(x4, 41);
    return {x4, x3, x2, x1, x0};
  endfunction

  function automatic logic [63:0] byte_mask(logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[63 - 8 * i -: 8] = (n > 4'(i)) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

  function automatic logic [63:0] pad_word(logic [2:0] pos);
    return {PAD_BYTE, 56'd0} >> {pos, 3'b000};
  endfunction

endpackage

// ===== rtl/ascon_ctrl.sv =====
// Sequencer for start, associated data, message and finish requests.
module ascon_ctrl
  import ascon_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;
  ctrl_state_t ret_r, ret_nxt;
  logic [3:0]  round_r, round_nxt;
  phase_t      phase_r, phase_nxt;
  logic        ad_started_r, ad_started_nxt;
  logic        fin_pad_r, fin_pad_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  data_start;
  logic        slot_free;
  logic        issue;

  assign data_start = status.wide ? ROUND_128A_START : ROUND_128_START;
  assign slot_free  = !out_valid_r || out_tready;
  assign issue      = ((state_r == ST_MSG) || (state_r == ST_TAG)) && slot_free;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ret_r        <= ST_IDLE;
      round_r      <= ROUND_FULL_START;
      phase_r      <= PH_IDLE;
      ad_started_r <= 1'b0;
      fin_pad_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      round_r      <= round_nxt;
      phase_r      <= phase_nxt;
      ad_started_r <= ad_started_nxt;
      fin_pad_r    <= fin_pad_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    round_nxt      = round_r;
    phase_nxt      = phase_r;
    ad_started_nxt = ad_started_r;
    fin_pad_nxt    = fin_pad_r;
    out_valid_nxt  = issue || (out_valid_r && !out_tready);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.kind)
          KIND_START: begin
            state_nxt      = ST_ROUND;
            round_nxt      = ROUND_FULL_START;
            ret_nxt        = ST_INIT_KEY;
            phase_nxt      = PH_AD;
            ad_started_nxt = 1'b0;
          end
          KIND_AD: begin
            if (phase_r == PH_AD) begin
              if (status.full) begin
                ad_started_nxt = 1'b1;
                state_nxt      = ST_ROUND;
                round_nxt      = data_start;
                ret_nxt        = ST_IDLE;
              end else begin
                phase_nxt = PH_MSG;
                if (ad_started_r || status.nonzero) begin
                  state_nxt = ST_ROUND;
                  round_nxt = data_start;
                  ret_nxt   = ST_SEP;
                end else begin
                  state_nxt = ST_SEP;
                end
              end
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          KIND_MSG: begin
            if (phase_r == PH_AD) begin
              phase_nxt = PH_MSG;
              if (ad_started_r) begin
                state_nxt = ST_ROUND;
                round_nxt = data_start;
                ret_nxt   = ST_SEP;
              end else begin
                state_nxt = ST_SEP;
              end
            end else if (phase_r == PH_MSG) begin
              state_nxt = ST_MSG;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          KIND_FIN: begin
            case (phase_r)
              PH_AD: begin
                fin_pad_nxt = 1'b1;
                if (ad_started_r) begin
                  state_nxt = ST_ROUND;
                  round_nxt = data_start;
                  ret_nxt   = ST_SEP;
                end else begin
                  state_nxt = ST_SEP;
                end
              end
              PH_MSG: begin
                fin_pad_nxt = 1'b1;
                state_nxt   = ST_FIN_KEY;
              end
              PH_DONE: begin
                fin_pad_nxt = 1'b0;
                state_nxt   = ST_FIN_KEY;
              end
              default: begin
                state_nxt = ST_IDLE;
              end
            endcase
            if (phase_r != PH_IDLE) begin
              phase_nxt      = PH_IDLE;
              ad_started_nxt = 1'b0;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_ROUND: begin
        if (round_r == ROUND_LAST) begin
          state_nxt = ret_r;
        end else begin
          round_nxt = round_r + 4'd1;
        end
      end
      ST_INIT_KEY: begin
        state_nxt = ST_IDLE;
      end
      ST_SEP: begin
        case (status.kind)
          KIND_MSG: state_nxt = ST_MSG;
          KIND_FIN: state_nxt = ST_FIN_KEY;
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_MSG: begin
        if (slot_free) begin
          if (status.full) begin
            state_nxt = ST_ROUND;
            round_nxt = data_start;
            ret_nxt   = ST_IDLE;
          end else begin
            phase_nxt = PH_DONE;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FIN_KEY: begin
        state_nxt = ST_ROUND;
        round_nxt = ROUND_FULL_START;
        ret_nxt   = ST_TAG;
      end
      ST_TAG: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    cmd.op        = DP_NOP;
    cmd.round_idx = round_r;
    cmd.pad_en    = 1'b0;
    cmd.load_item = in_tvalid && (state_r == ST_IDLE);
    case (state_r)
      ST_DECODE: begin
        case (status.kind)
          KIND_START: begin
            cmd.op = DP_LOAD;
          end
          KIND_AD: begin
            if (phase_r == PH_AD) begin
              cmd.op     = DP_AD_ABS;
              cmd.pad_en = !status.full && (ad_started_r || status.nonzero);
            end
          end
          default: begin
            if ((phase_r == PH_AD) && ad_started_r) begin
              cmd.op = DP_PAD0;
            end
          end
        endcase
      end
      ST_ROUND:    cmd.op = DP_ROUND;
      ST_INIT_KEY: cmd.op = DP_INIT_KEY;
      ST_SEP:      cmd.op = DP_SEP;
      ST_MSG: begin
        if (slot_free) begin
          cmd.op     = DP_MSG;
          cmd.pad_en = !status.full;
        end
      end
      ST_FIN_KEY: begin
        cmd.op     = DP_FIN_KEY;
        cmd.pad_en = fin_pad_r;
      end
      ST_TAG: begin
        if (slot_free) begin
          cmd.op = DP_TAG;
        end
      end
      default: begin
        cmd.op = DP_NOP;
      end
    endcase
  end

endmodule

// ===== rtl/ascon_dp.sv =====
// State, key registers, round unit, absorb and tag logic of the Ascon engine.
module ascon_dp
  import ascon_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic [TDATA_W-1:0] in_tdata,
  input  logic [1:0]         in_tuser,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  output logic [TDATA_W-1:0] out_tdata,
  output logic               out_tuser
);

  logic [1:0]  variant_r;
  logic        decrypt_r;
  logic [31:0] key_extra_r;
  logic [63:0] key_hi_r;
  logic [63:0] key_lo_r;

  state_t      x_r, x_nxt;
  logic [63:0] d_hi_r, d_lo_r;
  logic [4:0]  cnt_r;
  item_kind_t  kind_r;

  logic [63:0] o_hi_r, o_lo_r;
  logic [4:0]  o_cnt_r;
  logic        o_kind_r;
  logic        o_ok_r;

  logic        wide, pq;
  logic [4:0]  rate, c, c_m8;
  logic [3:0]  n0, n1;
  logic [63:0] m0, m1, padv, pad0v, pad1v;
  logic [63:0] e0, e1, y0, y1, o0, o1;
  logic [63:0] t3, t4;
  logic [31:0] iv;

  assign wide = (variant_r == VAR_128A);
  assign pq   = (variant_r == VAR_80PQ);
  assign rate = wide ? RATE_WIDE : RATE_NARROW;
  assign c    = (cnt_r > rate) ? rate : cnt_r;
  assign c_m8 = c - {1'b0, LANE_BYTES};
  assign n0   = (c >= {1'b0, LANE_BYTES}) ? LANE_BYTES : c[3:0];
  assign n1   = (wide && (c > {1'b0, LANE_BYTES})) ? c_m8[3:0] : 4'd0;
  assign m0   = byte_mask(n0);
  assign m1   = byte_mask(n1);
  assign padv  = pad_word(c[2:0]);
  assign pad0v = (cmd.pad_en && !c[3]) ? padv : 64'd0;
  assign pad1v = (cmd.pad_en && c[3]) ? padv : 64'd0;

  assign e0 = x_r[0] ^ (d_hi_r & m0);
  assign e1 = x_r[1] ^ (d_lo_r & m1);
  assign y0 = (x_r[0] & ~m0) | (d_hi_r & m0);
  assign y1 = (x_r[1] & ~m1) | (d_lo_r & m1);
  assign o0 = decrypt_r ? ((x_r[0] ^ d_hi_r) & m0) : (e0 & m0);
  assign o1 = decrypt_r ? ((x_r[1] ^ d_lo_r) & m1) : (e1 & m1);
  assign t3 = x_r[3] ^ key_hi_r;
  assign t4 = x_r[4] ^ key_lo_r;
  assign iv = wide ? IV_128A : IV_128;

  assign status.kind    = kind_r;
  assign status.full    = (c == rate);
  assign status.nonzero = (c != 5'd0);
  assign status.wide    = wide;

  assign out_tdata = {2'b00, o_ok_r, o_cnt_r, o_lo_r, o_hi_r};
  assign out_tuser = o_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r   <= VAR_128;
      decrypt_r   <= 1'b0;
      key_extra_r <= '0;
      key_hi_r    <= '0;
      key_lo_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_VARIANT:   variant_r   <= cfg_data[1:0];
        CFG_DECRYPT:   decrypt_r   <= cfg_data[0];
        CFG_KEY_EXTRA: key_extra_r <= cfg_data[31:0];
        CFG_KEY_HI:    key_hi_r    <= cfg_data;
        CFG_KEY_LO:    key_lo_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    x_nxt = x_r;
    case (cmd.op)
      DP_LOAD: begin
        x_nxt[0] = pq ? {IV_80PQ, key_extra_r} : {iv, 32'd0};
        x_nxt[1] = key_hi_r;
        x_nxt[2] = key_lo_r;
        x_nxt[3] = d_hi_r;
        x_nxt[4] = d_lo_r;
      end
      DP_ROUND: begin
        x_nxt = ascon_round(x_r, cmd.round_idx);
      end
      DP_INIT_KEY: begin
        x_nxt[2] = x_r[2] ^ (pq ? {32'd0, key_extra_r} : 64'd0);
        x_nxt[3] = t3;
        x_nxt[4] = t4;
      end
      DP_AD_ABS: begin
        x_nxt[0] = e0 ^ pad0v;
        x_nxt[1] = e1 ^ pad1v;
      end
      DP_PAD0: begin
        x_nxt[0] = x_r[0] ^ {PAD_BYTE, 56'd0};
      end
      DP_SEP: begin
        x_nxt[4] = x_r[4] ^ 64'd1;
      end
      DP_MSG: begin
        x_nxt[0] = (decrypt_r ? y0 : e0) ^ pad0v;
        x_nxt[1] = (decrypt_r ? y1 : e1) ^ pad1v;
      end
      DP_FIN_KEY: begin
        x_nxt[0] = x_r[0] ^ (cmd.pad_en ? {PAD_BYTE, 56'd0} : 64'd0);
        if (pq) begin
          x_nxt[1] = x_r[1] ^ {key_extra_r, key_hi_r[63:32]};
          x_nxt[2] = x_r[2] ^ {key_hi_r[31:0], key_lo_r[63:32]};
          x_nxt[3] = x_r[3] ^ {key_lo_r[31:0], 32'd0};
        end else if (wide) begin
          x_nxt[2] = x_r[2] ^ key_hi_r;
          x_nxt[3] = x_r[3] ^ key_lo_r;
        end else begin
          x_nxt[1] = x_r[1] ^ key_hi_r;
          x_nxt[2] = x_r[2] ^ key_lo_r;
        end
      end
      DP_TAG: begin
        x_nxt[3] = t3;
        x_nxt[4] = t4;
      end
      default: begin
        x_nxt = x_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
    end else begin
      x_r <= x_nxt;
    end
    if (cmd.load_item) begin
      d_hi_r <= in_tdata[63:0];
      d_lo_r <= in_tdata[127:64];
      cnt_r  <= in_tdata[132:128];
      kind_r <= item_kind_t'(in_tuser);
    end
    if (cmd.op == DP_MSG) begin
      o_hi_r   <= o0;
      o_lo_r   <= o1;
      o_cnt_r  <= c;
      o_kind_r <= OUT_KIND_DATA;
      o_ok_r   <= 1'b0;
    end else if (cmd.op == DP_TAG) begin
      o_hi_r   <= decrypt_r ? 64'd0 : t3;
      o_lo_r   <= decrypt_r ? 64'd0 : t4;
      o_cnt_r  <= TAG_BYTES;
      o_kind_r <= OUT_KIND_TAG;
      o_ok_r   <= decrypt_r && (t3 == d_hi_r) && (t4 == d_lo_r);
    end
  end

endmodule

// ===== rtl/ascon_aead_engine_core.sv =====
// Top level of the Ascon-80pq / 128 / 128a AEAD engine.
// One item at a time is processed; a new request is taken whenever the
// sequencer is idle, even while the previous result still waits in the
// output register. One permutation round per cycle in a single round unit
// sets the timing. A start request passes through decode and load, 12 rounds,
// key add and accept; a full associated-data block through decode, the data
// rounds and accept; a final associated-data block also through separation,
// or only decode, separation and accept when it is empty and nothing was
// absorbed before; a full message block through decode, output write, the
// data rounds and accept, and a final message block through decode, output
// write and accept. Closing the associated data from a message or finish
// request adds the data rounds and separation when a padding block is needed
// and separation alone otherwise, and a finish request passes through decode,
// key add, 12 rounds, tag and accept. A message or finish request stalls
// while the output register holds a result that has not been taken.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only be issued while idle.
module ascon_aead_engine_core
  import ascon_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_tvalid,
  output logic               in_tready,
  // word_hi[63:0], word_lo[127:64], byte_count[132:128], zero fill
  input  logic [TDATA_W-1:0] in_tdata,
  // kind[1:0]
  input  logic [1:0]         in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  // out_hi[63:0], out_lo[127:64], out_count[132:128], tag_ok[133], zero fill
  output logic [TDATA_W-1:0] out_tdata,
  // out_kind[0]
  output logic               out_tuser
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  ascon_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  ascon_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// ===== rtl/ascon_chk.sv =====
// Port-level checker for the Ascon AEAD engine, bound to the top level.
module ascon_chk
  import ascon_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic               out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one still decoding");

  a_data_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == OUT_KIND_DATA) |-> !out_tdata[133] &&
      (out_tdata[132:128] <= RATE_WIDE))
    else $error("data block with tag flag or bad count");

  a_tag_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == OUT_KIND_TAG) |-> out_tdata[132:128] == TAG_BYTES)
    else $error("tag result with wrong count");

  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[135:134] == 2'b00)
    else $error("nonzero fill bits in result");

endmodule

bind ascon_aead_engine_core ascon_chk u_chk (.*);

// ===== test/ascon_aead_engine_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ascon_aead_engine_core with an in-bench Ascon AEAD model.
module ascon_aead_engine_core_tb
  import ascon_pkg::*;
();

  localparam int DRAIN_CYCLES = 40;
  localparam logic [31:0] INIT_80PQ = 32'hA040_0C06;
  localparam logic [31:0] INIT_128  = 32'h8040_0C06;
  localparam logic [31:0] INIT_128A = 32'h8080_0C08;

  typedef struct {
    logic        kind;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  count;
    logic        ok;
  } aead_out_t;

  class aead_scoreboard;
    logic [63:0] lane [5];
    phase_t      phase;
    bit          ad_seen;
    logic [1:0]  variant;
    bit          decrypt;
    logic [31:0] key_x;
    logic [63:0] key_h;
    logic [63:0] key_l;
    aead_out_t   awaited_out [$];
    int          errors;
    int          checked;
    int          tags;
    int          verified;

    function new();
      foreach (lane[i]) lane[i] = '0;
      phase    = PH_IDLE;
      ad_seen  = 1'b0;
      variant  = VAR_128;
      decrypt  = 1'b0;
      key_x    = '0;
      key_h    = '0;
      key_l    = '0;
      errors   = 0;
      checked  = 0;
      tags     = 0;
      verified = 0;
    endfunction

    function int rate_bytes();
      return (variant == VAR_128A) ? 16 : 8;
    endfunction

    function int rounds_data();
      return (variant == VAR_128A) ? 8 : 6;
    endfunction

    function logic [63:0] ror(logic [63:0] v, int n);
      logic [127:0] w;
      w = {v, v} >> n;
      return w[63:0];
    endfunction

    function logic [63:0] mask(int n);
      if (n <= 0) return '0;
      if (n >= 8) return '1;
      return ~64'd0 << (64 - 8 * n);
    endfunction

    function void permute(int rounds);
      logic [63:0] x0, x1, x2, x3, x4;
      logic [63:0] t0, t1, t2, t3, t4;
      for (int r = 12 - rounds; r < 12; r++) begin
        x0 = lane[0];
        x1 = lane[1];
        x2 = lane[2] ^ {56'd0, 4'(15 - r), 4'(r)};
        x3 = lane[3];
        x4 = lane[4];
        x0 ^= x4;
        x4 ^= x3;
        x2 ^= x1;
        t0 = ~x0 & x1;
        t1 = ~x1 & x2;
        t2 = ~x2 & x3;
        t3 = ~x3 & x4;
        t4 = ~x4 & x0;
        x0 ^= t1;
        x1 ^= t2;
        x2 ^= t3;
        x3 ^= t4;
        x4 ^= t0;
        x1 ^= x0;
        x0 ^= x4;
        x3 ^= x2;
        x2 = ~x2;
        lane[0] = x0 ^ ror(x0, 19) ^ ror(x0, 28);
        lane[1] = x1 ^ ror(x1, 61) ^ ror(x1, 39);
        lane[2] = x2 ^ ror(x2, 1) ^ ror(x2, 6);
        lane[3] = x3 ^ ror(x3, 10) ^ ror(x3, 17);
        lane[4] = x4 ^ ror(x4, 7) ^ ror(x4, 41);
      end
    endfunction

    function void pad(int c);
      lane[(c / 8) & 1] ^= 64'h80 << (56 - 8 * (c % 8));
    endfunction

    function void close_ad(int c);
      if (ad_seen || c > 0) begin
        pad(c);
        permute(rounds_data());
      end
      lane[4] ^= 64'd1;
      phase = PH_MSG;
    endfunction

    function void finalize();
      if (phase == PH_AD) close_ad(0);
      if (phase == PH_MSG) pad(0);
      if (variant == VAR_80PQ) begin
        lane[1] ^= {key_x, key_h[63:32]};
        lane[2] ^= {key_h[31:0], key_l[63:32]};
        lane[3] ^= {key_l[31:0], 32'd0};
      end else if (variant == VAR_128A) begin
        lane[2] ^= key_h;
        lane[3] ^= key_l;
      end else begin
        lane[1] ^= key_h;
        lane[2] ^= key_l;
      end
      permute(12);
      lane[3] ^= key_h;
      lane[4] ^= key_l;
      phase   = PH_IDLE;
      ad_seen = 1'b0;
    endfunction

    function void peek_tag(output logic [63:0] t_hi, output logic [63:0] t_lo);
      logic [63:0] saved [5];
      phase_t      saved_phase;
      bit          saved_seen;
      saved       = lane;
      saved_phase = phase;
      saved_seen  = ad_seen;
      finalize();
      t_hi    = lane[3];
      t_lo    = lane[4];
      lane    = saved;
      phase   = saved_phase;
      ad_seen = saved_seen;
    endfunction

    function void set_reg(cfg_index_t idx, logic [63:0] v);
      case (idx)
        CFG_VARIANT:   variant = v[1:0];
        CFG_DECRYPT:   decrypt = v[0];
        CFG_KEY_EXTRA: key_x = v[31:0];
        CFG_KEY_HI:    key_h = v;
        CFG_KEY_LO:    key_l = v;
        default: ;
      endcase
    endfunction

    function void take_request(item_kind_t kind, logic [63:0] w_hi, logic [63:0] w_lo,
                               logic [4:0] cnt);
      logic [63:0] blk [2];
      logic [63:0] res [2];
      logic [63:0] m;
      int          rate;
      int          c;
      aead_out_t   e;
      blk[0] = w_hi;
      blk[1] = w_lo;
      res[0] = '0;
      res[1] = '0;
      rate   = rate_bytes();
      c      = (int'(cnt) > rate) ? rate : int'(cnt);
      case (kind)
        KIND_START: begin
          if (variant == VAR_80PQ) lane[0] = {INIT_80PQ, key_x};
          else if (variant == VAR_128A) lane[0] = {INIT_128A, 32'd0};
          else lane[0] = {INIT_128, 32'd0};
          lane[1] = key_h;
          lane[2] = key_l;
          lane[3] = blk[0];
          lane[4] = blk[1];
          permute(12);
          if (variant == VAR_80PQ) lane[2] ^= {32'd0, key_x};
          lane[3] ^= key_h;
          lane[4] ^= key_l;
          phase   = PH_AD;
          ad_seen = 1'b0;
        end
        KIND_AD: begin
          if (phase == PH_AD) begin
            for (int j = 0; j < rate / 8; j++) lane[j] ^= blk[j] & mask(c - 8 * j);
            if (c == rate) begin
              permute(rounds_data());
              ad_seen = 1'b1;
            end else begin
              close_ad(c);
            end
          end
        end
        KIND_MSG: begin
          if (phase == PH_AD) close_ad(0);
          if (phase == PH_MSG) begin
            for (int j = 0; j < rate / 8; j++) begin
              m = mask(c - 8 * j);
              if (decrypt) begin
                res[j]  = (lane[j] ^ blk[j]) & m;
                lane[j] = (lane[j] & ~m) | (blk[j] & m);
              end else begin
                lane[j] ^= blk[j] & m;
                res[j]  = lane[j] & m;
              end
            end
            if (c == rate) begin
              permute(rounds_data());
            end else begin
              pad(c);
              phase = PH_DONE;
            end
            e.kind  = OUT_KIND_DATA;
            e.hi    = res[0];
            e.lo    = res[1];
            e.count = 5'(c);
            e.ok    = 1'b0;
            awaited_out.push_back(e);
          end
        end
        default: begin
          if (phase != PH_IDLE) begin
            finalize();
            e.kind  = OUT_KIND_TAG;
            e.count = 5'd16;
            if (decrypt) begin
              e.hi = '0;
              e.lo = '0;
              e.ok = (lane[3] == blk[0]) && (lane[4] == blk[1]);
            end else begin
              e.hi = lane[3];
              e.lo = lane[4];
              e.ok = 1'b0;
            end
            tags++;
            if (e.ok) verified++;
            awaited_out.push_back(e);
          end
        end
      endcase
    endfunction

    function void check_result(logic [TDATA_W-1:0] d, logic u);
      aead_out_t e;
      if (awaited_out.size() == 0) begin
        $error("unexpected result: tdata %h tuser %b", d, u);
        errors++;
        return;
      end
      e = awaited_out.pop_front();
      checked++;
      if (u !== e.kind) begin
        $error("out_kind: expected %0d, got %0d", e.kind, u);
        errors++;
      end
      if (d[63:0] !== e.hi) begin
        $error("out_hi: expected %h, got %h", e.hi, d[63:0]);
        errors++;
      end
      if (d[127:64] !== e.lo) begin
        $error("out_lo: expected %h, got %h", e.lo, d[127:64]);
        errors++;
      end
      if (d[132:128] !== e.count) begin
        $error("out_count: expected %0d, got %0d", e.count, d[132:128]);
        errors++;
      end
      if (d[133] !== e.ok) begin
        $error("tag_ok: expected %0d, got %0d", e.ok, d[133]);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [63:0]        cfg_data;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;
  logic [1:0]         in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tuser;

  aead_scoreboard sb;
  int             tx_idle_pct;
  int             rx_idle_pct;
  int             hold_left;
  int             n_sent;
  int             cfg_round;

  ascon_aead_engine_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  function automatic logic [63:0] rnd_word();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [4:0] full_count(int rate);
    if ($urandom_range(7) == 0) return 5'($urandom_range(31, rate));
    return 5'(rate);
  endfunction

  task automatic send_req(item_kind_t kind, logic [63:0] w_hi, logic [63:0] w_lo,
                          logic [4:0] cnt);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'd0, cnt, w_lo, w_hi};
    do @(posedge clk); while (!in_tready);
    sb.take_request(kind, w_hi, w_lo, cnt);
    n_sent++;
  endtask

  task automatic send_noise();
    send_req(item_kind_t'($urandom_range(3)), rnd_word(), rnd_word(), 5'($urandom));
  endtask

  task automatic write_reg(cfg_index_t idx, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_settings(logic [1:0] var_sel, bit dec, logic [63:0] kx,
                                logic [63:0] kh, logic [63:0] kl);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(CFG_VARIANT, {junk[63:2], var_sel});
    write_reg(CFG_DECRYPT, {junk[63:1], dec});
    write_reg(CFG_KEY_EXTRA, kx);
    write_reg(CFG_KEY_HI, kh);
    write_reg(CFG_KEY_LO, kl);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.awaited_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_session(int max_msg);
    int          rate;
    int          n_ad;
    int          n_msg;
    logic [63:0] t_hi;
    logic [63:0] t_lo;
    rate  = sb.rate_bytes();
    n_ad  = $urandom_range(3);
    n_msg = $urandom_range(max_msg);
    send_req(KIND_START, rnd_word(), rnd_word(), 5'($urandom));
    repeat (n_ad) send_req(KIND_AD, rnd_word(), rnd_word(), full_count(rate));
    if ($urandom_range(1)) send_req(KIND_AD, rnd_word(), rnd_word(), 5'($urandom_range(rate - 1)));
    if ($urandom_range(15) == 0) send_noise();
    repeat (n_msg) send_req(KIND_MSG, rnd_word(), rnd_word(), full_count(rate));
    if ($urandom_range(1)) send_req(KIND_MSG, rnd_word(), rnd_word(), 5'($urandom_range(rate - 1)));
    if ($urandom_range(15) == 0) send_noise();
    if ($urandom_range(19) != 0) begin
      sb.peek_tag(t_hi, t_lo);
      case ($urandom_range(5))
        0: t_hi ^= 64'd1 << $urandom_range(63);
        1: t_lo ^= 64'd1 << $urandom_range(63);
        default: ;
      endcase
      send_req(KIND_FIN, t_hi, t_lo, 5'($urandom));
    end
  endtask

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    out_tready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_VARIANT;
    cfg_data    = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = KIND_START;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_left   = 0;
    n_sent      = 0;
    cfg_round   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_settings(VAR_128, 1'b0, '0, '0, '0);
    send_req(KIND_FIN, '1, '1, 5'd16);
    send_req(KIND_MSG, '1, '1, 5'd8);
    send_req(KIND_AD, '1, '1, 5'd8);
    send_req(KIND_START, '1, '1, 5'd0);
    send_req(KIND_AD, '1, '1, 5'd8);
    send_req(KIND_AD, 64'h0123_4567_89ab_cdef, '1, 5'd31);
    send_req(KIND_AD, '1, '0, 5'd3);
    send_req(KIND_AD, '1, '1, 5'd8);
    send_req(KIND_MSG, '1, '1, 5'd8);
    send_req(KIND_MSG, '1, '1, 5'd0);
    send_req(KIND_MSG, '1, '1, 5'd8);
    send_req(KIND_FIN, '0, '0, 5'd0);
    send_req(KIND_START, '0, '0, 5'd31);
    send_req(KIND_FIN, '1, '1, 5'd16);
    send_req(KIND_START, 64'hfedc_ba98_7654_3210, '0, 5'd1);
    send_req(KIND_AD, '1, '1, 5'd0);
    send_req(KIND_MSG, '1, '1, 5'd7);
    send_req(KIND_FIN, '0, '1, 5'd16);
    send_req(KIND_START, '1, '0, 5'd16);
    send_req(KIND_AD, '0, '0, 5'd8);
    send_req(KIND_MSG, '0, '0, 5'd8);
    send_req(KIND_FIN, '1, '0, 5'd16);
    send_req(KIND_START, '0, '1, 5'd8);
    send_req(KIND_START, '1, '1, 5'd8);
    send_req(KIND_FIN, '0, '0, 5'd0);

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 22 : (p == 1) ? 70 : 0;
      rx_idle_pct = (p == 0) ? 70 : (p == 1) ? 22 : 0;
      if (p == 0) begin
        wait_drained();
        apply_settings(VAR_128A, 1'b0, {$urandom, $urandom}, '1, {$urandom, $urandom});
        hold_left = 400;
        send_req(KIND_START, rnd_word(), rnd_word(), 5'd0);
        repeat (24) send_req(KIND_MSG, rnd_word(), rnd_word(), 5'd16);
        send_req(KIND_FIN, rnd_word(), rnd_word(), 5'd16);
      end
      while (n_sent < 25 + (p + 1) * 660) begin
        wait_drained();
        case ((cfg_round / 8) % 3)
          0: apply_settings(2'(cfg_round), cfg_round[2], '0, '0, '0);
          1: apply_settings(2'(cfg_round), cfg_round[2], '1, '1, '1);
          default: apply_settings(2'(cfg_round), cfg_round[2], {$urandom, $urandom},
                                  rnd_word(), rnd_word());
        endcase
        cfg_round++;
        repeat (6) begin
          if ($urandom_range(9) == 0) send_noise();
          else run_session(($urandom_range(7) == 0) ? 12 : 4);
        end
      end
    end

    wait_drained();
    $display("Sent %0d requests across all variants, both directions and three stall profiles",
             n_sent);
    $display("Checked %0d results, %0d of them tags, %0d decrypt verifies expected to pass",
             sb.checked, sb.tags, sb.verified);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
